@@ design/mbf_pkg.sv @@
`default_nettype none

package mbf_pkg;

  typedef enum logic [2:0] {
    OP_READ_POS   = 3'd0,
    OP_ZERO       = 3'd1,
    OP_STOP       = 3'd2,
    OP_MOVE_POS   = 3'd3,
    OP_MOVE_STEP  = 3'd4,
    OP_READ_STAT  = 3'd5
  } mbf_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } mbf_state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         device_addr;
    logic signed [31:0] value;
  } mbf_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } mbf_out_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FUNC_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FUNC_WRITE_MANY = 8'h10;

  localparam logic [15:0] REG_POSITION  = 16'd1000;
  localparam logic [15:0] REG_STATUS    = 16'd1004;
  localparam logic [15:0] REG_ZERO      = 16'd2000;
  localparam logic [15:0] REG_STOP      = 16'd2001;
  localparam logic [15:0] REG_TARGET    = 16'd2002;
  localparam logic [15:0] REG_STEP_FWD  = 16'd2004;
  localparam logic [15:0] REG_STEP_BACK = 16'd2006;

  localparam logic [7:0] WRITE_BYTE_COUNT = 8'h04;

  // Body lengths before the two CRC bytes
  localparam logic [3:0] BODY_LEN_SHORT = 4'd6;
  localparam logic [3:0] BODY_LEN_LONG  = 4'd11;

endpackage

`default_nettype wire

@@ design/mbf_crc_byte.sv @@
`default_nettype none

// CRC-16/Modbus update over one byte, LSB first
module mbf_crc_byte (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic [15:0]      crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mbf_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

@@ design/modbus_rtu_motor_command_framer.sv @@
`default_nettype none

// Modbus RTU motor command framer.
// Input channel (in_valid / in_stall / in_data): one motor command request
// carrying operation, device address and a signed value. The block raises
// in_stall for the whole time a frame is being sent, and takes the next
// request once the last byte has been loaded into the output register.
// Output channel (out_valid / out_stall / out_data): the frame one byte per
// transfer, CRC-16/Modbus low byte first, last_byte set on the final byte.
// Frames are 8 bytes (reads, zero, stop) or 13 bytes (moves). Unknown
// operation codes are accepted and dropped without any output.
// An accepted request is captured into the payload registers as the sequencer
// enters its send state; its bytes then go out through the output register.
// The byte rate is set by the single byte-wide CRC update unit, which folds in
// one body byte per cycle unless the receiver stalls, as that byte is loaded.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits; nothing is lost or repeated.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register; any frame in progress is abandoned.
module modbus_rtu_motor_command_framer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mbf_pkg::mbf_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mbf_pkg::mbf_out_t     out_data
);

  mbf_pkg::mbf_state_t state_r, state_nxt;

  // Captured frame fields
  logic [7:0]  addr_r;
  logic [7:0]  func_r;
  logic [15:0] reg_r;
  logic [15:0] qty_r;
  logic [31:0] val_r;
  logic [3:0]  body_len_r;

  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  mbf_pkg::mbf_out_t out_data_r, out_data_nxt;

  // Decode of the incoming request
  logic        op_ok;
  logic [7:0]  dec_func;
  logic [15:0] dec_reg;
  logic [15:0] dec_qty;
  logic [31:0] dec_val;
  logic [3:0]  dec_len;
  logic [31:0] raw_val;
  logic        accept;

  logic        advance;
  logic [3:0]  last_idx;
  logic [7:0]  body_byte;
  logic [15:0] crc_upd;

  assign raw_val = in_data.value;

  always_comb begin
    op_ok    = 1'b1;
    dec_func = mbf_pkg::FUNC_READ_HOLD;
    dec_reg  = mbf_pkg::REG_POSITION;
    dec_qty  = 16'd2;
    dec_val  = raw_val;
    dec_len  = mbf_pkg::BODY_LEN_SHORT;
    case (in_data.operation)
      mbf_pkg::OP_READ_POS: begin
        dec_func = mbf_pkg::FUNC_READ_HOLD;
        dec_reg  = mbf_pkg::REG_POSITION;
        dec_qty  = 16'd2;
      end
      mbf_pkg::OP_ZERO: begin
        dec_func = mbf_pkg::FUNC_WRITE_ONE;
        dec_reg  = mbf_pkg::REG_ZERO;
        dec_qty  = 16'd0;
      end
      mbf_pkg::OP_STOP: begin
        dec_func = mbf_pkg::FUNC_WRITE_ONE;
        dec_reg  = mbf_pkg::REG_STOP;
        dec_qty  = 16'd0;
      end
      mbf_pkg::OP_MOVE_POS: begin
        dec_func = mbf_pkg::FUNC_WRITE_MANY;
        dec_reg  = mbf_pkg::REG_TARGET;
        dec_qty  = 16'd2;
        dec_len  = mbf_pkg::BODY_LEN_LONG;
      end
      mbf_pkg::OP_MOVE_STEP: begin
        dec_func = mbf_pkg::FUNC_WRITE_MANY;
        dec_qty  = 16'd2;
        dec_len  = mbf_pkg::BODY_LEN_LONG;
        // Negative step: send the magnitude on the reverse register;
        // the most negative value wraps onto itself
        if (raw_val[31]) begin
          dec_reg = mbf_pkg::REG_STEP_BACK;
          dec_val = 32'd0 - raw_val;
        end else begin
          dec_reg = mbf_pkg::REG_STEP_FWD;
        end
      end
      mbf_pkg::OP_READ_STAT: begin
        dec_func = mbf_pkg::FUNC_READ_HOLD;
        dec_reg  = mbf_pkg::REG_STATUS;
        dec_qty  = 16'd1;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // Body byte selection by position in the frame
  always_comb begin
    case (idx_r)
      4'd0:    body_byte = addr_r;
      4'd1:    body_byte = func_r;
      4'd2:    body_byte = reg_r[15:8];
      4'd3:    body_byte = reg_r[7:0];
      4'd4:    body_byte = qty_r[15:8];
      4'd5:    body_byte = qty_r[7:0];
      4'd6:    body_byte = mbf_pkg::WRITE_BYTE_COUNT;
      4'd7:    body_byte = val_r[31:24];
      4'd8:    body_byte = val_r[23:16];
      4'd9:    body_byte = val_r[15:8];
      4'd10:   body_byte = val_r[7:0];
      default: body_byte = 8'h00;
    endcase
  end

  mbf_crc_byte u_crc (
    .crc_in  (crc_r),
    .data    (body_byte),
    .crc_out (crc_upd)
  );

  assign last_idx = body_len_r + 4'd1;
  assign accept   = (state_r == mbf_pkg::ST_IDLE) && in_valid;
  assign advance  = (state_r == mbf_pkg::ST_SEND) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbf_pkg::ST_IDLE: begin
        if (in_valid && op_ok) begin
          state_nxt = mbf_pkg::ST_SEND;
        end
      end
      mbf_pkg::ST_SEND: begin
        if (advance && (idx_r == last_idx)) begin
          state_nxt = mbf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: load the output register, fold each body byte into the CRC
  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    in_stall      = 1'b1;
    case (state_r)
      mbf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        idx_nxt  = 4'd0;
        crc_nxt  = mbf_pkg::CRC_INIT;
      end
      mbf_pkg::ST_SEND: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + 4'd1;
          if (idx_r < body_len_r) begin
            out_data_nxt.frame_byte = body_byte;
            out_data_nxt.last_byte  = 1'b0;
            crc_nxt                 = crc_upd;
          end else if (idx_r == body_len_r) begin
            out_data_nxt.frame_byte = crc_r[7:0];
            out_data_nxt.last_byte  = 1'b0;
          end else begin
            out_data_nxt.frame_byte = crc_r[15:8];
            out_data_nxt.last_byte  = 1'b1;
          end
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Payload fields capture on acceptance and hold; CRC and output byte update
  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      addr_r     <= in_data.device_addr;
      func_r     <= dec_func;
      reg_r      <= dec_reg;
      qty_r      <= dec_qty;
      val_r      <= dec_val;
      body_len_r <= dec_len;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ test/frame_checker.sv @@
// Watches both channels of the command framer, rebuilds every Modbus RTU
// request frame from the accepted command and checks the bytes in order.
module frame_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  mbf_pkg::mbf_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  mbf_pkg::mbf_out_t out_data,
  output int                mismatches,
  output int                outstanding
);
  import mbf_pkg::*;

  mbf_out_t frame_q[$];
  mbf_out_t want;
  int       fail_count = 0;
  int       pending    = 0;

  assign mismatches  = fail_count;
  assign outstanding = pending;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Queue the full frame that one command should produce; spare codes give nothing.
  function automatic void predict_frame(input mbf_in_t req);
    logic [7:0]  body[$];
    logic [7:0]  func;
    logic [15:0] regaddr;
    logic [15:0] qty;
    logic [15:0] crc;
    logic [31:0] word;
    logic        wide;
    word = req.value;
    wide = 1'b0;
    case (req.operation)
      OP_READ_POS:  begin func = FUNC_READ_HOLD;  regaddr = REG_POSITION; qty = 16'd2; end
      OP_READ_STAT: begin func = FUNC_READ_HOLD;  regaddr = REG_STATUS;   qty = 16'd1; end
      OP_ZERO:      begin func = FUNC_WRITE_ONE;  regaddr = REG_ZERO;     qty = 16'd0; end
      OP_STOP:      begin func = FUNC_WRITE_ONE;  regaddr = REG_STOP;     qty = 16'd0; end
      OP_MOVE_POS: begin
        func = FUNC_WRITE_MANY; regaddr = REG_TARGET; qty = 16'd2; wide = 1'b1;
      end
      OP_MOVE_STEP: begin
        func = FUNC_WRITE_MANY; regaddr = REG_STEP_FWD; qty = 16'd2; wide = 1'b1;
        // negative step: send the magnitude, which wraps for the most negative value
        if (word[31]) begin
          regaddr = REG_STEP_BACK;
          word    = ~word + 32'd1;
        end
      end
      default: return;
    endcase
    body = '{req.device_addr, func, regaddr[15:8], regaddr[7:0], qty[15:8], qty[7:0]};
    if (wide) begin
      body = {body, WRITE_BYTE_COUNT, word[31:24], word[23:16], word[15:8], word[7:0]};
    end
    crc = CRC_INIT;
    foreach (body[k]) crc = crc_fold(crc, body[k]);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    foreach (body[k]) begin
      frame_q.push_back('{frame_byte: body[k], last_byte: (k == body.size() - 1)});
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_frame(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        $error("unexpected frame byte %h last_byte %b", out_data.frame_byte, out_data.last_byte);
        fail_count++;
      end else begin
        want = frame_q.pop_front();
        if (out_data.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %h, got %h", want.frame_byte, out_data.frame_byte);
          fail_count++;
        end
        if (out_data.last_byte !== want.last_byte) begin
          $error("last_byte: expected %b, got %b", want.last_byte, out_data.last_byte);
          fail_count++;
        end
      end
    end
    pending = frame_q.size();
  end

endmodule

@@ test/testbench.sv @@
// Stimulus and verdict for the Modbus RTU command framer; all checking
// happens in frame_checker, which sits beside the block on the same wires.
module testbench;
  import mbf_pkg::*;

  // Operation codes that the block accepts and drops without a frame
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Frames needed from the random part, and a hard ceiling on the run
  localparam int RANDOM_FRAMES = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  mbf_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mbf_out_t out_data;

  int       mismatches;
  int       outstanding;
  int       cycles = 0;
  // While set, neither side idles: gives a long stretch at full rate
  bit       calm   = 1'b0;

  modbus_rtu_motor_command_framer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  frame_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the frame output in about a fifth of cycles, except in the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 20);
  end

  // Abandon the run once it reaches the cycle ceiling
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic mbf_in_t make_request(input logic [2:0] op, input logic [7:0] addr,
                                           input logic [31:0] word);
    mbf_in_t req;
    req.operation   = op;
    req.device_addr = addr;
    req.value       = word;
    return req;
  endfunction

  // Offer one command request, idling first at random, and hold it until taken.
  // The valid is only touched at a falling edge, once per edge.
  task automatic send_request(input mbf_in_t req);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Favour the edges of the signed range so both step directions and the wrap appear
  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          frames_sent;
    logic [2:0]  op;
    frames_sent = 0;

    // Hold reset low, then release it at a falling edge
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every operation, address extremes, value extremes on both moves
    send_request(make_request(OP_READ_POS,  8'h00, 32'h0000_0000));
    send_request(make_request(OP_READ_STAT, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_ZERO,      8'h01, 32'h7FFF_FFFF));
    send_request(make_request(OP_STOP,      8'hAA, 32'h8000_0000));
    send_request(make_request(OP_MOVE_POS,  8'h11, 32'h0000_0000));
    send_request(make_request(OP_MOVE_POS,  8'hFF, 32'h7FFF_FFFF));
    send_request(make_request(OP_MOVE_POS,  8'h00, 32'h8000_0000));
    send_request(make_request(OP_MOVE_POS,  8'h55, 32'hFFFF_FFFF));
    send_request(make_request(OP_MOVE_POS,  8'h7E, 32'h1234_5678));
    // Forward steps use the forward register, negative ones send the magnitude
    send_request(make_request(OP_MOVE_STEP, 8'h02, 32'h0000_0000));
    send_request(make_request(OP_MOVE_STEP, 8'h03, 32'h0000_0001));
    send_request(make_request(OP_MOVE_STEP, 8'hFE, 32'h7FFF_FFFF));
    send_request(make_request(OP_MOVE_STEP, 8'h80, 32'hFFFF_FFFF));
    send_request(make_request(OP_MOVE_STEP, 8'h81, 32'hEDCB_A988));
    // Most negative step: magnitude wraps back onto itself
    send_request(make_request(OP_MOVE_STEP, 8'h7F, 32'h8000_0000));
    // Spare codes are swallowed; surround them with frames to catch any leakage
    send_request(make_request(OP_SPARE_LO,  8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_READ_POS,  8'h55, 32'h0000_0000));
    send_request(make_request(OP_SPARE_HI,  8'h00, 32'h0000_0000));
    send_request(make_request(OP_READ_STAT, 8'h01, 32'h0000_0000));

    // Random: mostly real commands, a few spare codes, calm stretch in the middle
    while (frames_sent < RANDOM_FRAMES) begin
      calm = (frames_sent >= 150) && (frames_sent < 230);
      if ($urandom_range(99) < 8) begin
        op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else begin
        op = 3'($urandom_range(5));
        frames_sent++;
      end
      send_request(make_request(op, 8'($urandom_range(255)), random_word()));
    end

    // Drop the valid, let the remaining frames drain, then allow a short tail
    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
